// ===== sv/registered_buffer_fifo_macros.svh =====
// Assertion macros used by the registered buffer FIFO checker.
`ifndef REGISTERED_BUFFER_FIFO_MACROS_SVH
`define REGISTERED_BUFFER_FIFO_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RBF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("registered_buffer_fifo: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("registered_buffer_fifo: next-cycle check failed");

`endif

// ===== sv/rbf_pkg.sv =====
// Package with the types, constants and codes of the registered buffer FIFO.
package rbf_pkg;

  // Storage sizes.
  localparam int QUEUE_DEPTH    = 8;
  localparam int REGISTRY_DEPTH = 16;

  // Field widths fixed by the interface.
  localparam int ID_W    = 8;
  localparam int CAP_W   = 4;
  localparam int QCOUT_W = 4;

  // Widths derived from the storage sizes.
  localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int Q_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int R_IDX_W = (REGISTRY_DEPTH > 1) ? $clog2(REGISTRY_DEPTH) : 1;
  localparam int CMP_W   = (Q_CNT_W > CAP_W) ? Q_CNT_W : CAP_W;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_REG   = 2'd2,
    CMD_UNREG = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOT_REG  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_REG_FULL = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_EXEC,
    S_PURGE,
    S_RESULT
  } state_t;

  // Input item.
  typedef struct packed {
    logic [1:0]      cmd;
    logic [ID_W-1:0] buffer_id;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [2:0]         status;
    logic [ID_W-1:0]    out_buffer_id;
    logic               queue_empty;
    logic [QCOUT_W-1:0] queue_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic match;
    logic exec;
    logic purge_step;
    logic out_load;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_unreg;
    logic purge_last;
  } dp_stat_t;

endpackage

// ===== sv/registered_buffer_fifo.sv =====
// Top level of the registered buffer FIFO: controller and datapath.
//
// Each input item carries a command (enqueue, dequeue, register handle,
// unregister handle) and an 8-bit buffer handle; each item gives exactly one
// result item with status, dequeued handle, empty flag and queue count.
// Both item channels use valid and stall: an item moves on a rising edge with
// valid high and stall low. The block works on one item at a time; in_stall
// is low only while the controller is idle.
// Enqueue, dequeue and register pass registry compare, execute and result
// load before the result shows; the next item is taken back in idle.
// Unregister adds a purge pass between execute and load, one queue entry per
// cycle plus a closing step that writes back the count of entries kept.
// The next item is accepted while a result still waits in the output
// register; while out_stall is high the result holds and the following item
// waits in its final state until the register frees.
// The capacity register is written through cfg_valid/cfg_ready (always ready)
// and must only be written while the block is idle.
// A synchronous reset (rst_n low) empties the queue and the registry and sets
// the capacity to 8.
module registered_buffer_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rbf_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rbf_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rbf_pkg::CAP_W-1:0]     cfg_data
);

  rbf_pkg::ctl_cmd_t cmd;
  rbf_pkg::dp_stat_t stat;

  // The capacity register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // Controller.
  rbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath.
  rbf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

endmodule

// ===== sv/rbf_ctrl.sv =====
// Controller state machine of the registered buffer FIFO.
module rbf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rbf_pkg::dp_stat_t stat,
  output rbf_pkg::ctl_cmd_t cmd
);

  rbf_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  // The output register can take a result when it is empty or being emptied.
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands to the datapath.
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_nxt  = out_valid_r && out_stall;
    case (state_r)
      rbf_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = rbf_pkg::S_MATCH;
        end
      end
      rbf_pkg::S_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = rbf_pkg::S_EXEC;
      end
      rbf_pkg::S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.is_unreg ? rbf_pkg::S_PURGE : rbf_pkg::S_RESULT;
      end
      rbf_pkg::S_PURGE: begin
        cmd.purge_step = 1'b1;
        if (stat.purge_last) begin
          state_nxt = rbf_pkg::S_RESULT;
        end
      end
      rbf_pkg::S_RESULT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = rbf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rbf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/rbf_datapath.sv =====
// Datapath of the registered buffer FIFO: queue, registry, capacity and result register.
module rbf_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rbf_pkg::in_item_t                in_item,
  input  logic                             cfg_valid,
  input  logic [rbf_pkg::CAP_W-1:0]        cfg_data,
  input  rbf_pkg::ctl_cmd_t                cmd,
  output rbf_pkg::dp_stat_t                stat,
  output rbf_pkg::out_item_t               out_item
);

  localparam int QD = rbf_pkg::QUEUE_DEPTH;
  localparam int RD = rbf_pkg::REGISTRY_DEPTH;

  // Captured item.
  rbf_pkg::cmd_t                   item_cmd_r;
  logic [rbf_pkg::ID_W-1:0]        item_id_r;

  // Queue storage, entry 0 is the oldest.
  logic [rbf_pkg::ID_W-1:0]        slot_r [QD];
  logic [rbf_pkg::Q_CNT_W-1:0]     count_r;

  // Registry storage and the registered match and free vectors.
  logic [rbf_pkg::ID_W-1:0]        reg_slot_r [RD];
  logic [RD-1:0]                   reg_valid_r;
  logic [RD-1:0]                   match_r;
  logic [RD-1:0]                   free_r;

  // Capacity register.
  logic [rbf_pkg::CAP_W-1:0]       cap_r;

  // Result of the executed command.
  rbf_pkg::status_t                status_r;
  logic [rbf_pkg::ID_W-1:0]        got_r;

  // Purge pass read and write pointers.
  logic [rbf_pkg::Q_CNT_W-1:0]     rd_r;
  logic [rbf_pkg::Q_CNT_W-1:0]     kept_r;

  logic [rbf_pkg::CMP_W-1:0]       eff_cap;
  logic                            full;
  logic                            registered;
  logic                            has_free;
  logic [rbf_pkg::R_IDX_W-1:0]     free_idx;
  logic [rbf_pkg::R_IDX_W-1:0]     match_idx;
  logic [rbf_pkg::ID_W-1:0]        rd_data;
  logic                            purge_last;
  logic                            purge_keep;
  logic                            enq_ok;
  logic                            deq_ok;
  rbf_pkg::status_t                exec_status;

  // Effective capacity: zero acts as one, values past the depth saturate.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = rbf_pkg::CMP_W'(1);
    end else if (rbf_pkg::CMP_W'(cap_r) > rbf_pkg::CMP_W'(QD)) begin
      eff_cap = rbf_pkg::CMP_W'(QD);
    end else begin
      eff_cap = rbf_pkg::CMP_W'(cap_r);
    end
  end

  assign full       = rbf_pkg::CMP_W'(count_r) >= eff_cap;
  assign registered = |match_r;
  assign has_free   = |free_r;
  assign enq_ok     = (item_cmd_r == rbf_pkg::CMD_ENQ) && !full && registered;
  assign deq_ok     = (item_cmd_r == rbf_pkg::CMD_DEQ) && (count_r != '0);

  // Lowest free and lowest matching registry slots.
  always_comb begin
    free_idx  = '0;
    match_idx = '0;
    for (int i = RD - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        free_idx = rbf_pkg::R_IDX_W'(i);
      end
      if (match_r[i]) begin
        match_idx = rbf_pkg::R_IDX_W'(i);
      end
    end
  end

  // Purge pass: one queue entry is examined per cycle.
  assign rd_data    = slot_r[rd_r[rbf_pkg::Q_IDX_W-1:0]];
  assign purge_last = (rd_r == count_r);
  assign purge_keep = (rd_data != item_id_r);

  assign stat.is_unreg   = (item_cmd_r == rbf_pkg::CMD_UNREG);
  assign stat.purge_last = purge_last;

  // Status of the command in execution.
  always_comb begin
    case (item_cmd_r)
      rbf_pkg::CMD_ENQ: begin
        if (full) begin
          exec_status = rbf_pkg::ST_FULL;
        end else if (!registered) begin
          exec_status = rbf_pkg::ST_NOT_REG;
        end else begin
          exec_status = rbf_pkg::ST_OK;
        end
      end
      rbf_pkg::CMD_DEQ: begin
        exec_status = (count_r == '0) ? rbf_pkg::ST_EMPTY : rbf_pkg::ST_OK;
      end
      rbf_pkg::CMD_REG: begin
        exec_status = has_free ? rbf_pkg::ST_OK : rbf_pkg::ST_REG_FULL;
      end
      default: begin
        exec_status = rbf_pkg::ST_OK;
      end
    endcase
  end

  // Control state: capacity, queue count, registry valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= rbf_pkg::CAP_RESET;
      count_r     <= '0;
      reg_valid_r <= '0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (cmd.exec && enq_ok) begin
        count_r <= count_r + rbf_pkg::Q_CNT_W'(1);
      end else if (cmd.exec && deq_ok) begin
        count_r <= count_r - rbf_pkg::Q_CNT_W'(1);
      end else if (cmd.purge_step && purge_last) begin
        count_r <= kept_r;
      end
      if (cmd.exec && (item_cmd_r == rbf_pkg::CMD_REG) && has_free) begin
        reg_valid_r[free_idx] <= 1'b1;
      end else if (cmd.exec && (item_cmd_r == rbf_pkg::CMD_UNREG) && registered) begin
        reg_valid_r[match_idx] <= 1'b0;
      end
    end
  end

  // Captured item, match vectors and execution results.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_cmd_r <= rbf_pkg::cmd_t'(in_item.cmd);
      item_id_r  <= in_item.buffer_id;
    end
    if (cmd.match) begin
      for (int i = 0; i < RD; i++) begin
        match_r[i] <= reg_valid_r[i] && (reg_slot_r[i] == item_id_r);
        free_r[i]  <= !reg_valid_r[i];
      end
    end
    if (cmd.exec) begin
      status_r <= exec_status;
      got_r    <= deq_ok ? slot_r[0] : '0;
      rd_r     <= '0;
      kept_r   <= '0;
    end else if (cmd.purge_step && !purge_last) begin
      rd_r <= rd_r + rbf_pkg::Q_CNT_W'(1);
      if (purge_keep) begin
        kept_r <= kept_r + rbf_pkg::Q_CNT_W'(1);
      end
    end
  end

  // Queue entries: shift on dequeue, append on enqueue, compact on purge.
  always_ff @(posedge clk) begin
    if (cmd.exec && deq_ok) begin
      for (int i = 0; i < QD - 1; i++) begin
        slot_r[i] <= slot_r[i+1];
      end
    end else if (cmd.exec && enq_ok) begin
      slot_r[count_r[rbf_pkg::Q_IDX_W-1:0]] <= item_id_r;
    end else if (cmd.purge_step && !purge_last && purge_keep) begin
      slot_r[kept_r[rbf_pkg::Q_IDX_W-1:0]] <= rd_data;
    end
  end

  // Registry handles.
  always_ff @(posedge clk) begin
    if (cmd.exec && (item_cmd_r == rbf_pkg::CMD_REG) && has_free) begin
      reg_slot_r[free_idx] <= item_id_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.status        <= status_r;
      out_item.out_buffer_id <= got_r;
      out_item.queue_empty   <= (count_r == '0);
      out_item.queue_count   <= rbf_pkg::QCOUT_W'(count_r);
    end
  end

endmodule

// ===== sv/rbf_checker.sv =====
// Port-level checker of the registered buffer FIFO and its bind statement.
`include "registered_buffer_fifo_macros.svh"

module rbf_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input rbf_pkg::out_item_t        out_item
);

  logic out_empty_st;
  logic out_empty_ok;
  logic out_has_id;
  logic out_ok_st;

  // Result flags used by the checks below.
  assign out_empty_st = out_valid && (out_item.status == rbf_pkg::ST_EMPTY);
  assign out_empty_ok = out_item.queue_empty && (out_item.out_buffer_id == '0);
  assign out_has_id   = out_valid && (out_item.out_buffer_id != '0);
  assign out_ok_st    = (out_item.status == rbf_pkg::ST_OK);

  // An accepted item keeps the input closed in the next cycle.
  `RBF_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall)

  // A stalled result holds.
  `RBF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))

  // An empty dequeue reports an empty queue and no handle.
  `RBF_ASSERT_IMPLY(a_empty_result, clk, rst_n, out_empty_st, out_empty_ok)

  // A handle appears only with an ok status.
  `RBF_ASSERT_IMPLY(a_handle_ok, clk, rst_n, out_has_id, out_ok_st)

endmodule

bind registered_buffer_fifo rbf_checker u_rbf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
